// ===== sv/geap_pkg.sv =====
// ----------------------------------------------------------------------------
// geap_pkg: shared constants for the equal-area polar grid classifier
// Register indexes and reset values, glyph codes, fixed field widths and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package geap_pkg;

	// default values of the top-level parameters
	localparam int COORD_BITS_DEF    = 10;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// fixed widths of the configuration fields
	localparam int CELL_W   = 4;
	localparam int UNIT_W   = 10;
	localparam int SCNT_W   = 7;
	localparam int RBAND_W  = 7;
	localparam int SBAND_W  = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int GLYPH_W  = 3;
	localparam int GUARD_BITS = 16;
	localparam int ATAN_LEN   = 20;
	// unit squared and band times count
	localparam int DIV_W = 2 * UNIT_W;
	localparam int BN_W  = SBAND_W + SCNT_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_UNIT   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_CNT  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_BAND   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BAND = 4'd7;

	// reset values
	localparam int RST_CENTER_COL  = 40;
	localparam int RST_CENTER_ROW  = 12;
	localparam logic [CELL_W-1:0]  RST_CELL_WIDTH  = 4'd2;
	localparam logic [CELL_W-1:0]  RST_CELL_HEIGHT = 4'd4;
	localparam logic [UNIT_W-1:0]  RST_RING_UNIT   = 10'd288;
	localparam logic [SCNT_W-1:0]  RST_SECTOR_CNT  = 7'd12;
	localparam logic [RBAND_W-1:0] RST_RING_BAND   = 7'd15;
	localparam logic [SBAND_W-1:0] RST_SECTOR_BAND = 13'd1043;

	// glyph codes
	localparam logic [GLYPH_W-1:0] GLYPH_NONE      = 3'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_PLUS      = 3'd1;
	localparam logic [GLYPH_W-1:0] GLYPH_DASH      = 3'd2;
	localparam logic [GLYPH_W-1:0] GLYPH_BACKSLASH = 3'd3;
	localparam logic [GLYPH_W-1:0] GLYPH_BAR       = 3'd4;
	localparam logic [GLYPH_W-1:0] GLYPH_SLASH     = 3'd5;

	// atan(2^-i), 2^32 per turn, rounded
	localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

endpackage

// ===== sv/equal_area_polar_grid_pixel_classifier.sv =====
// ----------------------------------------------------------------------------
// equal_area_polar_grid_pixel_classifier
// Marks character cells that fall on the rings and sector lines of an
// equal-area polar grid and picks a line glyph for each marked cell.
// ----------------------------------------------------------------------------
// Usage:
//  - Item channel: col/row with item_valid; the block holds item_stall high
//    while its output skid stage is full. A beat moves when valid is high
//    and stall is low.
//  - Result channel: glyph/on_ring/on_spoke with result_valid; the receiver
//    drives result_stall.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//    is always high. Write only while no item is in flight.
//  - Throughput: one item per cycle, sustained, while result_stall stays low.
//  - Ring test: a restoring divider of 2*COORD_BITS+25 stages, one quotient
//    bit per stage, forms r^2 / unit^2 with 16 fraction bits and keeps the
//    low 8. The CORDIC runs alongside, one stage per step, and its angle is
//    delayed to meet the divider output.
//  - Reset: pipeline and output empty, registers take their default values.
//  - Stall: the pipeline keeps moving until the item behind a stalled result
//    lands in the skid stage; then the whole pipeline holds and item_stall
//    rises. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module equal_area_polar_grid_pixel_classifier #(
	parameter int COORD_BITS    = geap_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS    = geap_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = geap_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [COORD_BITS-1:0]               col,
	input  logic [COORD_BITS-1:0]               row,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [geap_pkg::GLYPH_W-1:0]        glyph,
	output logic                                on_ring,
	output logic                                on_spoke,
	// config channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [geap_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [geap_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CB     = COORD_BITS;
	localparam int AB     = ANGLE_BITS;
	localparam int CS     = CORDIC_STAGES;
	localparam int GB     = geap_pkg::GUARD_BITS;
	localparam int DW     = CB + 1 + geap_pkg::CELL_W;   // scaled offset
	localparam int SQ_W   = 2 * DW - 2;                   // one square
	localparam int R2_W   = SQ_W + 1;                     // r^2
	localparam int DIVW   = geap_pkg::DIV_W;
	localparam int DIV_N  = R2_W + 16;                    // quotient bits
	localparam int DLY    = DIV_N - CS;
	localparam int CX_W   = DW + GB + 3;
	localparam int BN_W   = geap_pkg::BN_W;
	localparam int CMP_W  = ((AB > BN_W) ? AB : BN_W) + 2;
	localparam int H_W    = AB - 1;
	localparam int GW     = geap_pkg::GLYPH_W;
	localparam int PH_W   = AB + geap_pkg::SCNT_W;

	localparam logic [CMP_W-1:0] TURN_C = CMP_W'(1) << AB;
	localparam logic [H_W-1:0]   T1_C   = H_W'(1) << (AB - 4);
	localparam logic [H_W-1:0]   T3_C   = H_W'(3) << (AB - 4);
	localparam logic [H_W-1:0]   T5_C   = H_W'(5) << (AB - 4);
	localparam logic [H_W-1:0]   T7_C   = H_W'(7) << (AB - 4);
	localparam logic [31:0]      RND_C  = 32'd1 << (31 - AB);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CB-1:0]                        center_col_q, center_row_q;
	logic [geap_pkg::CELL_W-1:0]          cell_width_q, cell_height_q;
	logic [geap_pkg::UNIT_W-1:0]          ring_unit_q;
	logic [geap_pkg::SCNT_W-1:0]          sector_cnt_q;
	logic [geap_pkg::RBAND_W-1:0]         ring_band_q;
	logic [geap_pkg::SBAND_W-1:0]         sector_band_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q  <= CB'(geap_pkg::RST_CENTER_COL);
			center_row_q  <= CB'(geap_pkg::RST_CENTER_ROW);
			cell_width_q  <= geap_pkg::RST_CELL_WIDTH;
			cell_height_q <= geap_pkg::RST_CELL_HEIGHT;
			ring_unit_q   <= geap_pkg::RST_RING_UNIT;
			sector_cnt_q  <= geap_pkg::RST_SECTOR_CNT;
			ring_band_q   <= geap_pkg::RST_RING_BAND;
			sector_band_q <= geap_pkg::RST_SECTOR_BAND;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				geap_pkg::CFG_CENTER_COL:  center_col_q  <= CB'(cfg_data[9:0]);
				geap_pkg::CFG_CENTER_ROW:  center_row_q  <= CB'(cfg_data[9:0]);
				geap_pkg::CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[3:0];
				geap_pkg::CFG_CELL_HEIGHT: cell_height_q <= cfg_data[3:0];
				geap_pkg::CFG_RING_UNIT:   ring_unit_q   <= cfg_data[9:0];
				geap_pkg::CFG_SECTOR_CNT:  sector_cnt_q  <= cfg_data[6:0];
				geap_pkg::CFG_RING_BAND:   ring_band_q   <= cfg_data[6:0];
				geap_pkg::CFG_SECTOR_BAND: sector_band_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// derived constants: unit^2, clamped count, band times count
	logic [DIVW-1:0]             div_d_q;
	logic [geap_pkg::SCNT_W-1:0] scnt_q;
	logic [BN_W-1:0]             bn_q;
	logic [geap_pkg::UNIT_W-1:0] ru_c;
	logic [geap_pkg::SCNT_W-1:0] sc_c;

	always_comb begin
		ru_c = (ring_unit_q == '0) ? geap_pkg::UNIT_W'(1) : ring_unit_q;
		sc_c = (sector_cnt_q == '0) ? geap_pkg::SCNT_W'(1) : sector_cnt_q;
	end

	always_ff @(posedge clk) begin
		div_d_q <= DIVW'(ru_c) * DIVW'(ru_c);
		scnt_q  <= sc_c;
		bn_q    <= BN_W'(sector_band_q) * BN_W'(sc_c);
	end

	// ------------------------------------------------------------------
	// pipeline enable: hold everything while the skid stage is full
	// ------------------------------------------------------------------
	logic skid_full_q;
	logic pipe_en;

	assign pipe_en    = !skid_full_q;
	assign item_stall = skid_full_q;

	// ------------------------------------------------------------------
	// S1: cell offsets, S2: pixel offsets, S3: squares and CORDIC entry
	// ------------------------------------------------------------------
	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [CB:0]   ddx_s1, ddy_s1;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;

	logic signed [DW-1:0]   ddx_ext, ddy_ext;
	logic signed [2*DW-1:0] dx_prod, dy_prod, sqx_prod, sqy_prod;
	logic signed [CX_W-1:0] gx_ext, gy_ext;

	always_comb begin
		ddx_ext  = {{(DW-CB-1){ddx_s1[CB]}}, ddx_s1};
		ddy_ext  = {{(DW-CB-1){ddy_s1[CB]}}, ddy_s1};
		dx_prod  = (2*DW)'(ddx_ext) *
		           (2*DW)'($signed({{(DW-geap_pkg::CELL_W){1'b0}}, cell_width_q}));
		dy_prod  = (2*DW)'(ddy_ext) *
		           (2*DW)'($signed({{(DW-geap_pkg::CELL_W){1'b0}}, cell_height_q}));
		sqx_prod = (2*DW)'(dx_s2) * (2*DW)'(dx_s2);
		sqy_prod = (2*DW)'(dy_s2) * (2*DW)'(dy_s2);
		gx_ext   = {{(CX_W-DW-GB){dx_s2[DW-1]}}, dx_s2, {GB{1'b0}}};
		gy_ext   = {{(CX_W-DW-GB){dy_s2[DW-1]}}, dy_s2, {GB{1'b0}}};
	end

	// CORDIC registers, index 0 is the S3 entry point
	logic signed [CX_W-1:0] cx_s [0:CS];
	logic signed [CX_W-1:0] cy_s [0:CS];
	logic [31:0]            cz_s [0:CS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ddx_s1 <= $signed({1'b0, col}) - $signed({1'b0, center_col_q});
			ddy_s1 <= $signed({1'b0, row}) - $signed({1'b0, center_row_q});
			dx_s2  <= dx_prod[DW-1:0];
			dy_s2  <= dy_prod[DW-1:0];
			sqx_s3 <= sqx_prod[SQ_W-1:0];
			sqy_s3 <= sqy_prod[SQ_W-1:0];
			// left half plane turns by a half turn first
			if (dx_s2 < 0) begin
				cx_s[0] <= -gx_ext;
				cy_s[0] <= -gy_ext;
				cz_s[0] <= 32'h80000000;
			end else begin
				cx_s[0] <= gx_ext;
				cy_s[0] <= gy_ext;
				cz_s[0] <= 32'h0;
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring, one micro-rotation per stage
	// ------------------------------------------------------------------
	logic signed [CX_W-1:0] cx_nx [0:CS-1];
	logic signed [CX_W-1:0] cy_nx [0:CS-1];
	logic [31:0]            cz_nx [0:CS-1];

	always_comb begin
		for (int i = 0; i < CS; i++) begin
			if (!cy_s[i][CX_W-1]) begin
				cx_nx[i] = cx_s[i] + (cy_s[i] >>> i);
				cy_nx[i] = cy_s[i] - (cx_s[i] >>> i);
				cz_nx[i] = cz_s[i] + geap_pkg::ATAN_TURN[i];
			end else begin
				cx_nx[i] = cx_s[i] - (cy_s[i] >>> i);
				cy_nx[i] = cy_s[i] + (cx_s[i] >>> i);
				cz_nx[i] = cz_s[i] - geap_pkg::ATAN_TURN[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < CS; i++) begin
				cx_s[i+1] <= cx_nx[i];
				cy_s[i+1] <= cy_nx[i];
				cz_s[i+1] <= cz_nx[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// angle rounding and sector phase, then delay to meet the divider
	// ------------------------------------------------------------------
	logic [AB-1:0]   ang_s [0:DLY];
	logic [AB-1:0]   ph_s  [0:DLY];
	logic [31:0]     z_rnd;
	logic [AB-1:0]   ang_c;
	logic [PH_W-1:0] ph_prod;

	always_comb begin
		z_rnd   = cz_s[CS] + RND_C;
		ang_c   = z_rnd[31 -: AB];
		ph_prod = PH_W'(ang_c) * PH_W'(scnt_q);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ang_s[0] <= ang_c;
			ph_s[0]  <= ph_prod[AB-1:0];
			for (int i = 0; i < DLY; i++) begin
				ang_s[i+1] <= ang_s[i];
				ph_s[i+1]  <= ph_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// S4 and divider: index 0 holds r^2, each stage adds a quotient bit
	// ------------------------------------------------------------------
	logic              dv_vld_s  [0:DIV_N];
	logic [DIVW-1:0]   dv_rem_s  [0:DIV_N];
	logic [R2_W-1:0]   dv_num_s  [0:DIV_N];
	logic [7:0]        dv_quo_s  [0:DIV_N];
	logic              dv_near_s [0:DIV_N];
	logic              dv_gt9_s  [0:DIV_N];

	logic [R2_W-1:0]   r2_c;
	logic [DIVW:0]     dv_trial [0:DIV_N-1];
	logic [DIVW:0]     dv_diff  [0:DIV_N-1];
	logic              dv_ge    [0:DIV_N-1];

	always_comb begin
		r2_c = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		for (int i = 0; i < DIV_N; i++) begin
			dv_trial[i] = {dv_rem_s[i], dv_num_s[i][R2_W-1]};
			dv_diff[i]  = dv_trial[i] - {1'b0, div_d_q};
			dv_ge[i]    = dv_trial[i] >= {1'b0, div_d_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_N; i++) dv_vld_s[i] <= 1'b0;
		end else if (pipe_en) begin
			dv_vld_s[0] <= vld_s3;
			for (int i = 0; i < DIV_N; i++) dv_vld_s[i+1] <= dv_vld_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dv_rem_s[0]  <= '0;
			dv_num_s[0]  <= r2_c;
			dv_quo_s[0]  <= '0;
			dv_near_s[0] <= r2_c < R2_W'(9);
			dv_gt9_s[0]  <= r2_c > R2_W'(9);
			for (int i = 0; i < DIV_N; i++) begin
				dv_rem_s[i+1]  <= dv_ge[i] ? dv_diff[i][DIVW-1:0]
				                           : dv_trial[i][DIVW-1:0];
				dv_num_s[i+1]  <= {dv_num_s[i][R2_W-2:0], 1'b0};
				dv_quo_s[i+1]  <= {dv_quo_s[i][6:0], dv_ge[i]};
				dv_near_s[i+1] <= dv_near_s[i];
				dv_gt9_s[i+1]  <= dv_gt9_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// final stage: ring and sector tests, glyph choice
	// ------------------------------------------------------------------
	logic          fin_vld_s;
	logic [GW-1:0] fin_glyph_s;
	logic          fin_ring_s, fin_sect_s;

	logic [7:0]       frac_c;
	logic [CMP_W-1:0] p_ext, bn_ext;
	logic [H_W-1:0]   h_c;
	logic             ring_c, sect_c;
	logic [GW-1:0]    glyph_c;

	always_comb begin
		frac_c = dv_quo_s[DIV_N];
		p_ext  = CMP_W'(ph_s[DLY]);
		bn_ext = CMP_W'(bn_q);
		h_c    = ang_s[DLY][H_W-1:0];
		ring_c = !dv_near_s[DIV_N] &&
		         ((frac_c < {1'b0, ring_band_q}) ||
		          (({1'b0, frac_c} + {2'b0, ring_band_q}) > 9'd256));
		sect_c = !dv_near_s[DIV_N] && dv_gt9_s[DIV_N] &&
		         ((p_ext < bn_ext) || ((p_ext + bn_ext) > TURN_C));
		if (ring_c && sect_c) begin
			glyph_c = geap_pkg::GLYPH_PLUS;
		end else if (ring_c || sect_c) begin
			if (h_c < T1_C || h_c >= T7_C) glyph_c = geap_pkg::GLYPH_DASH;
			else if (h_c < T3_C)           glyph_c = geap_pkg::GLYPH_BACKSLASH;
			else if (h_c < T5_C)           glyph_c = geap_pkg::GLYPH_BAR;
			else                           glyph_c = geap_pkg::GLYPH_SLASH;
		end else begin
			glyph_c = geap_pkg::GLYPH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s <= 1'b0;
		end else if (pipe_en) begin
			fin_vld_s <= dv_vld_s[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fin_glyph_s <= glyph_c;
			fin_ring_s  <= ring_c;
			fin_sect_s  <= sect_c;
		end
	end

	// ------------------------------------------------------------------
	// output register and skid stage
	// ------------------------------------------------------------------
	logic          res_valid_q;
	logic [GW-1:0] res_glyph_q, skid_glyph_q;
	logic          res_ring_q, skid_ring_q;
	logic          res_sect_q, skid_sect_q;
	logic          out_free;

	assign out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_free) begin
				res_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end
		end else if (out_free) begin
			res_valid_q <= fin_vld_s;
		end else if (fin_vld_s) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_free) begin
				res_glyph_q <= skid_glyph_q;
				res_ring_q  <= skid_ring_q;
				res_sect_q  <= skid_sect_q;
			end
		end else if (out_free) begin
			res_glyph_q <= fin_glyph_s;
			res_ring_q  <= fin_ring_s;
			res_sect_q  <= fin_sect_s;
		end else begin
			skid_glyph_q <= fin_glyph_s;
			skid_ring_q  <= fin_ring_s;
			skid_sect_q  <= fin_sect_s;
		end
	end

	assign result_valid = res_valid_q;
	assign glyph        = res_glyph_q;
	assign on_ring      = res_ring_q;
	assign on_spoke     = res_sect_q;

endmodule

// ===== tb/sv/polar_grid_checker.sv =====
// ----------------------------------------------------------------------------
// polar_grid_checker
// Watches the config, item and result channels of the polar grid classifier,
// tracks the register file, predicts the glyph and flags for every accepted
// cell and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module polar_grid_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  logic                              item_stall,
	input  logic [9:0]                        col,
	input  logic [9:0]                        row,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  logic [geap_pkg::GLYPH_W-1:0]      glyph,
	input  logic                              on_ring,
	input  logic                              on_spoke,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [geap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [geap_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                pending,
	output int                                fail_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [geap_pkg::GLYPH_W-1:0] glyph;
		logic                         on_ring;
		logic                         on_spoke;
	} cell_class_t;

	// shadow of the register file
	logic [9:0]                   grid_col;
	logic [9:0]                   grid_row;
	logic [geap_pkg::CELL_W-1:0]  pix_w;
	logic [geap_pkg::CELL_W-1:0]  pix_h;
	logic [geap_pkg::UNIT_W-1:0]  unit_len;
	logic [geap_pkg::SCNT_W-1:0]  slice_cnt;
	logic [geap_pkg::RBAND_W-1:0] ring_tol;
	logic [geap_pkg::SBAND_W-1:0] slice_tol;

	cell_class_t expected_cells[$];

	task automatic report(input string what, input cell_class_t got, input cell_class_t exp);
		fail_cnt++;
		$display("%0t mismatch %s: got g=%0d r=%0d s=%0d exp g=%0d r=%0d s=%0d", $realtime,
			what, got.glyph, got.on_ring, got.on_spoke, exp.glyph, exp.on_ring, exp.on_spoke);
	endtask

	// binary angle of (dx, dy), 65536 per turn, by CORDIC vectoring
	function automatic longint binary_angle(input longint dx, input longint dy);
		longint x, y, xs, ys;
		logic [31:0] z;
		x = dx * 65536;
		y = dy * 65536;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < geap_pkg::CORDIC_STAGES_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + geap_pkg::ATAN_TURN[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - geap_pkg::ATAN_TURN[i];
			end
		end
		z = z + 32'h0000_8000;
		return longint'(z[31:16]);
	endfunction

	function automatic cell_class_t classify_cell(input logic [9:0] c, input logic [9:0] r);
		longint dx, dy, r2, ru, n, k, f, a, p, bn, h;
		bit ring_hit, slice_hit;
		cell_class_t res;
		res = '0;
		dx = (longint'(c) - longint'(grid_col)) * longint'(pix_w);
		dy = (longint'(r) - longint'(grid_row)) * longint'(pix_h);
		r2 = dx * dx + dy * dy;
		// near the centre nothing is drawn
		if (r2 < 9)
			return res;
		ru = (unit_len == 0) ? 1 : longint'(unit_len);
		n  = (slice_cnt == 0) ? 1 : longint'(slice_cnt);
		k  = (r2 * 65536) / (ru * ru);
		f  = k & 255;
		ring_hit = (f < longint'(ring_tol)) || (f + longint'(ring_tol) > 256);
		a  = binary_angle(dx, dy);
		p  = (a * n) & 65535;
		bn = longint'(slice_tol) * n;
		slice_hit = (r2 > 9) && (p < bn || p > 65536 - bn);
		h  = a & 32767;
		if (ring_hit && slice_hit)
			res.glyph = geap_pkg::GLYPH_PLUS;
		else if (ring_hit || slice_hit) begin
			if (h < 4096 || h >= 7 * 4096)
				res.glyph = geap_pkg::GLYPH_DASH;
			else if (h < 3 * 4096)
				res.glyph = geap_pkg::GLYPH_BACKSLASH;
			else if (h < 5 * 4096)
				res.glyph = geap_pkg::GLYPH_BAR;
			else
				res.glyph = geap_pkg::GLYPH_SLASH;
		end
		res.on_ring  = ring_hit;
		res.on_spoke = slice_hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_class_t got, exp;
		if (!arst_n) begin
			pending   = 0;
			fail_cnt  = 0;
			grid_col  <= geap_pkg::RST_CENTER_COL;
			grid_row  <= geap_pkg::RST_CENTER_ROW;
			pix_w     <= geap_pkg::RST_CELL_WIDTH;
			pix_h     <= geap_pkg::RST_CELL_HEIGHT;
			unit_len  <= geap_pkg::RST_RING_UNIT;
			slice_cnt <= geap_pkg::RST_SECTOR_CNT;
			ring_tol  <= geap_pkg::RST_RING_BAND;
			slice_tol <= geap_pkg::RST_SECTOR_BAND;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					geap_pkg::CFG_CENTER_COL:  grid_col  <= cfg_data[9:0];
					geap_pkg::CFG_CENTER_ROW:  grid_row  <= cfg_data[9:0];
					geap_pkg::CFG_CELL_WIDTH:  pix_w     <= cfg_data[geap_pkg::CELL_W-1:0];
					geap_pkg::CFG_CELL_HEIGHT: pix_h     <= cfg_data[geap_pkg::CELL_W-1:0];
					geap_pkg::CFG_RING_UNIT:   unit_len  <= cfg_data[geap_pkg::UNIT_W-1:0];
					geap_pkg::CFG_SECTOR_CNT:  slice_cnt <= cfg_data[geap_pkg::SCNT_W-1:0];
					geap_pkg::CFG_RING_BAND:   ring_tol  <= cfg_data[geap_pkg::RBAND_W-1:0];
					geap_pkg::CFG_SECTOR_BAND: slice_tol <= cfg_data[geap_pkg::SBAND_W-1:0];
					default: ;
				endcase
			end
			// item beat: predict
			if (item_valid && !item_stall)
				expected_cells.push_back(classify_cell(col, row));
			// result beat: compare
			if (result_valid && !result_stall) begin
				got = '{glyph, on_ring, on_spoke};
				if (expected_cells.size() == 0)
					report("unexpected beat", got, '0);
				else begin
					exp = expected_cells.pop_front();
					if (got.glyph !== exp.glyph)
						report("glyph", got, exp);
					if (got.on_ring !== exp.on_ring)
						report("on_ring", got, exp);
					if (got.on_spoke !== exp.on_spoke)
						report("on_spoke", got, exp);
				end
			end
			pending = expected_cells.size();
		end
	end

endmodule

// ===== tb/sv/equal_area_polar_grid_pixel_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// equal_area_polar_grid_pixel_classifier_tb
// Drives cells through the classifier under a series of register settings,
// with random idle and stall patterns and one long result hold-off; the
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module equal_area_polar_grid_pixel_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 8;
	localparam int CELLS_PER_PH = 210;
	localparam int CYCLE_LIMIT  = 600000;

	// idle modes
	localparam int MODE_SEND_IDLE = 0;
	localparam int MODE_RECV_IDLE = 1;
	localparam int MODE_NO_IDLE   = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [9:0] col = '0;
	logic [9:0] row = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [geap_pkg::GLYPH_W-1:0] glyph;
	logic on_ring;
	logic on_spoke;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [geap_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [geap_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int pending;
	int fail_cnt;
	int idle_mode = MODE_SEND_IDLE;
	int cells_sent = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_cnt = 0;

	equal_area_polar_grid_pixel_classifier dut (.*);

	polar_grid_checker chk (.*);

	always #5 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off to fill the pipeline
	always @(posedge clk) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && cells_sent >= 300) begin
			result_stall <= 1'b1;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (idle_mode == MODE_SEND_IDLE)
			result_stall <= ($urandom_range(99) < 46);
		else if (idle_mode == MODE_RECV_IDLE)
			result_stall <= ($urandom_range(99) < 38);
		else
			result_stall <= 1'b0;
	end

	task automatic write_reg(input logic [geap_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= geap_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_grid(input int ccol, input int crow, input int cw, input int ch,
		input int unit, input int scnt, input int rband, input int sband);
		write_reg(geap_pkg::CFG_CENTER_COL, ccol);
		write_reg(geap_pkg::CFG_CENTER_ROW, crow);
		write_reg(geap_pkg::CFG_CELL_WIDTH, cw);
		write_reg(geap_pkg::CFG_CELL_HEIGHT, ch);
		write_reg(geap_pkg::CFG_RING_UNIT, unit);
		write_reg(geap_pkg::CFG_SECTOR_CNT, scnt);
		write_reg(geap_pkg::CFG_RING_BAND, rband);
		write_reg(geap_pkg::CFG_SECTOR_BAND, sband);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_cell(input int c, input int r);
		if (idle_mode == MODE_SEND_IDLE) begin
			while ($urandom_range(99) < 38) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end else if (idle_mode == MODE_RECV_IDLE) begin
			while ($urandom_range(99) < 46) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		col <= 10'(c);
		row <= 10'(r);
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		cells_sent++;
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int cc, cr, span;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit cells around (100, 100), default ring and sectors
		load_grid(100, 100, 1, 1, 288, 12, 15, 1043);
		send_cell(100, 100);	// centre
		send_cell(101, 100);
		send_cell(102, 102);	// r2 = 8
		send_cell(103, 100);	// r2 = 9 exactly, never a sector
		send_cell(100, 97);
		send_cell(97, 100);
		send_cell(120, 100);
		send_cell(80, 100);
		send_cell(100, 120);
		send_cell(100, 80);
		send_cell(114, 114);
		send_cell(86, 86);
		send_cell(114, 86);
		send_cell(86, 114);
		send_cell(118, 100);
		send_cell(0, 0);
		send_cell(1023, 1023);
		send_cell(0, 1023);
		send_cell(1023, 0);
		send_cell(682, 341);
		send_cell(341, 682);
		send_cell(118, 118);
		drain();
		// unwritten index must leave the registers alone
		write_reg(4'd15, 5);
		cfg_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_mode = (ph < 3) ? MODE_SEND_IDLE : (ph < 6) ? MODE_RECV_IDLE : MODE_NO_IDLE;
			drain();
			case (ph)
				0: load_grid(40, 12, 2, 4, 288, 12, 15, 1043);
				1: load_grid(0, 0, 1, 1, 16, 1, 0, 0);
				2: load_grid(1023, 1023, 15, 15, 1023, 64, 127, 8191);
				3: load_grid(512, 300, 3, 5, 0, 0, 40, 5000);
				4: load_grid(200, 700, 1, 2, 100, 127, 127, 600);
				5: load_grid(333, 444, 7, 9, 1023, 8, 64, 4096);
				default: load_grid($urandom_range(1023), $urandom_range(1023),
					$urandom_range(15, 1), $urandom_range(15, 1),
					$urandom_range(1023, 16), $urandom_range(64, 1),
					$urandom_range(127), $urandom_range(8191));
			endcase
			cc = (ph == 2) ? 1023 : (ph == 1) ? 0 : 40 * ph + 100;
			cr = (ph == 2) ? 1023 : (ph == 1) ? 0 : 30 * ph + 80;
			if (ph == 0) begin
				cc = 40;
				cr = 12;
			end
			for (int i = 0; i < CELLS_PER_PH; i++) begin
				// most cells near the centre; some anywhere
				if ($urandom_range(3) == 0)
					send_cell($urandom_range(1023), $urandom_range(1023));
				else begin
					span = $urandom_range(1) ? 8 : 60;
					send_cell((cc + $urandom_range(2 * span) - span) & 1023,
						(cr + $urandom_range(2 * span) - span) & 1023);
				end
			end
		end

		drain();
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
